[hw/rtl/pcxrle_pkg.sv]
// Package for the PCX run-length decoder.
// Holds the byte codes, the result status codes and the controller/datapath structs.
// No dependencies.
package pcxrle_pkg;

	localparam logic [7:0] MARKER_MASK = 8'hC0;
	localparam logic [5:0] RUN_MASK    = 6'h3F;

	localparam logic [1:0] ST_DATA    = 2'd0;
	localparam logic [1:0] ST_RAN_OUT = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;

	typedef struct packed {
		logic       restart;
		logic       load_pending;
		logic       start_run;
		logic       use_pending;
		logic       emit_data;
		logic       emit_err;
		logic [1:0] err_code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic rem_one;
		logic left_one;
		logic out_free;
		logic is_marker;
		logic in_eof;
	} dp_status_t;

endpackage

[hw/rtl/pcxrle_in_if.sv]
// Handshake interface for compressed input items of the PCX decoder.
// Carries valid, ready and the file byte with its end-of-file flag.
interface pcxrle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       end_of_file;

	modport source (output valid, output file_byte, output end_of_file, input ready);
	modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

[hw/rtl/pcxrle_out_if.sv]
// Handshake interface for decoded result items of the PCX decoder.
// Carries valid, ready, the decoded byte, the status code and the last flag.
interface pcxrle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output status, output last, input ready);
	modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

[hw/rtl/pcxrle_ctrl.sv]
// Controller state machine of the PCX decoder.
// Depends on pcxrle_pkg; drives the datapath through ctrl_cmd_t and reads dp_status_t.
module pcxrle_ctrl
	import pcxrle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t dp_status,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_ERR  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       stopped_q;
	logic       stopped_d;
	logic       run_pending_q;
	logic       run_pending_d;
	logic       eof_q;
	logic       eof_d;
	logic [1:0] err_code_q;
	logic [1:0] err_code_d;
	logic       in_fire;
	logic       active;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign active   = !stopped_q && !dp_status.rem_zero;

	always_comb begin
		state_d       = state_q;
		stopped_d     = stopped_q;
		run_pending_d = run_pending_q;
		eof_d         = eof_q;
		err_code_d    = err_code_q;
		cmd           = '0;
		cmd.err_code  = err_code_q;
		if (cfg_wr) begin
			cmd.restart   = 1'b1;
			state_d       = S_IDLE;
			stopped_d     = 1'b0;
			run_pending_d = 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && active) begin
						priority if (run_pending_q) begin
							cmd.start_run   = 1'b1;
							cmd.use_pending = 1'b1;
							run_pending_d   = 1'b0;
							eof_d           = dp_status.in_eof;
							state_d         = S_RUN;
						end else if (dp_status.is_marker) begin
							if (dp_status.in_eof) begin
								err_code_d = ST_TRUNC;
								state_d    = S_ERR;
							end else begin
								cmd.load_pending = 1'b1;
								run_pending_d    = 1'b1;
							end
						end else begin
							cmd.start_run = 1'b1;
							eof_d         = dp_status.in_eof;
							state_d       = S_RUN;
						end
					end
				end
				S_RUN: begin
					if (dp_status.out_free) begin
						cmd.emit_data = 1'b1;
						priority if (dp_status.rem_one) begin
							stopped_d = 1'b1;
							state_d   = S_IDLE;
						end else if (dp_status.left_one) begin
							if (eof_q) begin
								err_code_d = ST_RAN_OUT;
								state_d    = S_ERR;
							end else begin
								state_d = S_IDLE;
							end
						end else begin
							state_d = S_RUN;
						end
					end
				end
				S_ERR: begin
					if (dp_status.out_free) begin
						cmd.emit_err = 1'b1;
						stopped_d    = 1'b1;
						state_d      = S_IDLE;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			stopped_q     <= 1'b0;
			run_pending_q <= 1'b0;
			eof_q         <= 1'b0;
			err_code_q    <= ST_DATA;
		end else begin
			state_q       <= state_d;
			stopped_q     <= stopped_d;
			run_pending_q <= run_pending_d;
			eof_q         <= eof_d;
			err_code_q    <= err_code_d;
		end
	end

endmodule

[hw/rtl/pcxrle_dp.sv]
// Datapath of the PCX decoder: byte counters, run registers and the output register.
// Depends on pcxrle_pkg; obeys ctrl_cmd_t from pcxrle_ctrl and reports dp_status_t.
module pcxrle_dp
	import pcxrle_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       dp_status,
	input  logic [23:0]      target_length,
	input  logic [7:0]       file_byte,
	input  logic             end_of_file,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic [1:0]       status,
	output logic             last
);

	localparam logic [31:0] COUNT_MAX = (32'd1 << COUNT_WIDTH) - 32'd1;

	logic [COUNT_WIDTH-1:0] remaining_q;
	logic [5:0]             pend_len_q;
	logic [5:0]             run_left_q;
	logic [7:0]             run_byte_q;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic [1:0]             status_q;
	logic                   last_q;
	logic [31:0]            target_wide;
	logic [COUNT_WIDTH-1:0] target_sat;
	logic [5:0]             marker_len;

	assign target_wide = {8'd0, target_length};
	assign target_sat  = (target_wide > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
	                                               : target_wide[COUNT_WIDTH-1:0];
	assign marker_len  = ((file_byte[5:0] & RUN_MASK) == 6'd0) ? 6'd1
	                                                           : (file_byte[5:0] & RUN_MASK);

	assign dp_status.rem_zero  = (remaining_q == '0);
	assign dp_status.rem_one   = (remaining_q == COUNT_WIDTH'(1));
	assign dp_status.left_one  = (run_left_q == 6'd1);
	assign dp_status.out_free  = !out_valid_q || out_ready;
	assign dp_status.is_marker = ((file_byte & MARKER_MASK) == MARKER_MASK);
	assign dp_status.in_eof    = end_of_file;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			pend_len_q  <= 6'd0;
			run_left_q  <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				remaining_q <= target_sat;
				pend_len_q  <= 6'd0;
			end else if (cmd.emit_data) begin
				remaining_q <= remaining_q - COUNT_WIDTH'(1);
			end
			if (cmd.load_pending) begin
				pend_len_q <= marker_len;
			end
			if (cmd.start_run) begin
				run_left_q <= cmd.use_pending ? pend_len_q : 6'd1;
			end else if (cmd.emit_data) begin
				run_left_q <= run_left_q - 6'd1;
			end
			if (cmd.emit_data || cmd.emit_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_run) begin
			run_byte_q <= file_byte;
		end
		if (cmd.emit_data) begin
			out_byte_q <= run_byte_q;
			status_q   <= ST_DATA;
			last_q     <= dp_status.rem_one;
		end else if (cmd.emit_err) begin
			out_byte_q <= 8'd0;
			status_q   <= cmd.err_code;
			last_q     <= 1'b1;
		end
	end

endmodule

[hw/rtl/pcx_rle_decoder.sv]
// Top level of the PCX run-length decoder: register port, controller and datapath.
// Depends on pcxrle_pkg, pcxrle_in_if, pcxrle_out_if, pcxrle_ctrl and pcxrle_dp.
// A literal byte is taken into the run byte register, then copied into the output register once that is free;
// a new input byte is not accepted until the single run-emission state has passed it on.
// A run of n bytes goes into the output register one byte per cycle while the output register is free.
// Reset is asynchronous and clears the length to zero, so nothing is produced until written.
module pcx_rle_decoder
	import pcxrle_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	pcxrle_in_if.sink    in_ch,
	pcxrle_out_if.source out_ch,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [23:0] target_length_q;
	logic        cfg_wr;
	ctrl_cmd_t   cmd;
	dp_status_t  dp_status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
	assign prdata = (paddr == 2'd0) ? {8'd0, target_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_length_q <= 24'd0;
		end else if (cfg_wr) begin
			target_length_q <= pwdata[23:0];
		end
	end

	pcxrle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	pcxrle_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dp_status     (dp_status),
		.target_length (pwdata[23:0]),
		.file_byte     (in_ch.file_byte),
		.end_of_file   (in_ch.end_of_file),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_byte      (out_ch.out_byte),
		.status        (out_ch.status),
		.last          (out_ch.last)
	);

endmodule
